/* rtl/core/wpf_pkg.sv */
// Shared types, codes and constants for the waypoint proportional follower.
`default_nettype none

package wpf_pkg;

    // Widths of the arithmetic
    localparam int POS_W     = 32;
    localparam int IDX_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_W     = 48;                 // max_speed * |error| magnitude
    localparam int DIV_STEPS = NUM_W;              // one quotient bit per cycle
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Item actions
    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_LOAD    = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_SPEED      = 3'd0,
        REG_MIN_SPEED      = 3'd1,
        REG_ARRIVE_TOL     = 3'd2,
        REG_STEP_GAIN      = 3'd3,
        REG_WAYPOINT_COUNT = 3'd4
    } reg_index_t;

    // Register reset values
    localparam logic [15:0]      MAX_SPEED_RST      = 16'd19661;
    localparam logic [15:0]      MIN_SPEED_RST      = 16'd655;
    localparam logic [15:0]      ARRIVE_TOL_RST     = 16'd3;
    localparam logic [15:0]      STEP_GAIN_RST      = 16'd256;
    localparam logic [IDX_W-1:0] WAYPOINT_COUNT_RST = 5'd5;

    // A zero-length segment counts as one centimetre
    localparam logic [POS_W-1:0] MIN_SEG_LEN = 32'd256;

    typedef struct packed {
        logic [15:0]      max_speed;
        logic [15:0]      min_speed;
        logic [15:0]      arrive_tol;
        logic [15:0]      step_gain;
        logic [IDX_W-1:0] waypoint_count;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // tick transfer: form velocity increments
        logic load_we;     // load transfer: write table entry
        logic restart;     // restart transfer: clear course state
        logic pos_step;    // integrate position, update finished flag
        logic sel_prev;    // table read address = previous waypoint
        logic tgt_latch;   // take target entry from the table
        logic err_calc;    // errors and segment lengths
        logic mul_start;   // gain multiply, load dividers
        logic div_step;    // one quotient bit per axis
        logic fin_load;    // commands into result register, advance index on arrival
        logic done_load;   // finished result into result register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fin_now;     // course finished as of this tick
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/wpf_ifs.sv */
// Channel interfaces: request, result and configuration write.
`default_nettype none

interface wpf_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [3:0]         slot;
    logic signed [31:0] way_x;
    logic signed [31:0] way_y;

    modport source (output valid, action, vel_x, vel_y, slot, way_x, way_y, input ready);
    modport sink   (input valid, action, vel_x, vel_y, slot, way_x, way_y, output ready);
endinterface

interface wpf_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] cmd_x;
    logic signed [31:0] cmd_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [4:0]         target_index;
    logic               done_res;

    modport source (output valid, cmd_x, cmd_y, pos_x, pos_y, target_index, done_res,
                    input ready);
    modport sink   (input valid, cmd_x, cmd_y, pos_x, pos_y, target_index, done_res,
                    output ready);
endinterface

interface wpf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

/* rtl/core/wpf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wpf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/wpf_ctrl.sv */
// Controller: sequences one item through the datapath and owns the result valid.
`default_nettype none

module wpf_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    input  wire logic [1:0]          req_action,
    output logic                     req_ready,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    input  wire wpf_pkg::dp_status_t status,
    output wpf_pkg::dp_cmd_t         cmd
);
    import wpf_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_POS  = 8'b0000_0010,
        S_RDT  = 8'b0000_0100,
        S_RDP  = 8'b0000_1000,
        S_MUL  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    logic                   transfer;
    logic                   out_free;

    assign req_ready = (state_reg == S_IDLE);
    assign transfer  = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;

    // Next state and datapath commands
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (transfer)
                begin
                    unique case (action_t'(req_action))
                        ACT_TICK:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = S_POS;
                        end
                        ACT_LOAD:    cmd.load_we = 1'b1;
                        ACT_RESTART: cmd.restart = 1'b1;
                        ACT_NONE:    ;
                        default:     ;
                    endcase
                end
            end
            S_POS:
            begin
                cmd.pos_step = 1'b1;
                state_next   = status.fin_now ? S_DONE : S_RDT;
            end
            S_RDT:
            begin
                cmd.tgt_latch = 1'b1;
                cmd.sel_prev  = 1'b1;
                state_next    = S_RDP;
            end
            S_RDP:
            begin
                cmd.err_calc = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_start = 1'b1;
                div_cnt_next  = '0;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.fin_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.done_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Result valid: set on load, cleared on transfer
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.fin_load || cmd.done_load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/wpf_datapath.sv */
// Datapath: position integration, waypoint table, errors, gain multiply,
// two bit-serial dividers (one per axis) and the result register.
`default_nettype none

module wpf_datapath #(
    parameter int MAX_WAYPOINTS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wpf_pkg::dp_cmd_t   cmd,
    output wpf_pkg::dp_status_t     status,
    input  wire wpf_pkg::cfg_t      regs,
    input  wire logic signed [31:0] vel_x,
    input  wire logic signed [31:0] vel_y,
    input  wire logic [3:0]         slot,
    input  wire logic signed [31:0] way_x,
    input  wire logic signed [31:0] way_y,
    output logic signed [31:0]      cmd_x,
    output logic signed [31:0]      cmd_y,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic [4:0]              target_index,
    output logic                    done_res
);
    import wpf_pkg::*;

    localparam int AW = $clog2(MAX_WAYPOINTS);

    // Course state
    logic signed [POS_W-1:0]   pos_reg [2];
    logic [IDX_W-1:0]          idx_reg;
    logic                      fin_reg;

    // Per-axis working registers
    logic signed [POS_W+16:0]  prod_reg [2];    // velocity * step_gain
    logic signed [POS_W-1:0]   tgt_reg [2];
    logic [POS_W-1:0]          emag_reg [2];    // |error|
    logic                      neg_reg [2];     // error below zero
    logic                      arr_reg [2];     // within tolerance
    logic [POS_W-1:0]          len_reg [2];     // segment length, never zero
    logic [NUM_W-1:0]          quo_reg [2];     // dividend in, quotient out
    logic [POS_W-1:0]          rem_reg [2];

    // Result register
    logic signed [POS_W-1:0]   out_cmd_reg [2];
    logic signed [POS_W-1:0]   out_pos_reg [2];
    logic [IDX_W-1:0]          out_idx_reg;
    logic                      out_done_reg;

    logic signed [POS_W-1:0]   vel [2];
    logic signed [POS_W-1:0]   way [2];
    logic signed [POS_W-1:0]   prev [2];
    logic signed [16:0]        gain_s;
    logic [IDX_W-1:0]          count;
    logic [AW-1:0]             raddr;
    logic [2*POS_W-1:0]        rdata;
    logic                      slot_ok;

    logic signed [POS_W+1:0]   pos_sum [2];
    logic signed [POS_W-1:0]   pos_sat [2];
    logic signed [POS_W:0]     err [2];
    logic signed [POS_W:0]     seg [2];
    logic [POS_W:0]            err_abs [2];
    logic [POS_W:0]            seg_abs [2];
    logic [POS_W:0]            div_sh [2];
    logic [POS_W+1:0]          div_trial [2];
    logic [NUM_W-1:0]          mag_lim [2];
    logic [POS_W-1:0]          mag [2];
    logic signed [POS_W-1:0]   cmd_val [2];
    logic [IDX_W-1:0]          idx_inc;

    assign vel[0] = vel_x;
    assign vel[1] = vel_y;
    assign way[0] = $signed(rdata[2*POS_W-1:POS_W]);
    assign way[1] = $signed(rdata[POS_W-1:0]);
    assign gain_s = $signed({1'b0, regs.step_gain});

    // Effective course length: zero acts as one, capped at table depth
    always_comb
    begin
        if (regs.waypoint_count == '0)
        begin
            count = IDX_W'(1);
        end
        else if (32'(regs.waypoint_count) > MAX_WAYPOINTS)
        begin
            count = IDX_W'(MAX_WAYPOINTS);
        end
        else
        begin
            count = regs.waypoint_count;
        end
    end

    assign status.fin_now = fin_reg || (idx_reg >= count);
    assign idx_inc        = idx_reg + IDX_W'(1);

    // Waypoint table, entry = {x, y}
    assign slot_ok = (32'(slot) < MAX_WAYPOINTS);
    assign raddr   = cmd.sel_prev ? AW'(idx_reg - IDX_W'(1)) : AW'(idx_reg);

    wpf_ram #(
        .WIDTH (2*POS_W),
        .DEPTH (MAX_WAYPOINTS)
    ) u_table (
        .clk   (clk),
        .we    (cmd.load_we && slot_ok),
        .waddr (AW'(slot)),
        .wdata ({way_x, way_y}),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Per-axis combinational arithmetic
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            // position + (prod >>> 16), saturated
            pos_sum[a] = {{2{pos_reg[a][POS_W-1]}}, pos_reg[a]}
                       + {prod_reg[a][POS_W+16], prod_reg[a][POS_W+16:16]};
            if (pos_sum[a][POS_W+1:POS_W-1] == 3'b000 ||
                pos_sum[a][POS_W+1:POS_W-1] == 3'b111)
            begin
                pos_sat[a] = pos_sum[a][POS_W-1:0];
            end
            else if (pos_sum[a][POS_W+1])
            begin
                pos_sat[a] = {1'b1, {(POS_W-1){1'b0}}};
            end
            else
            begin
                pos_sat[a] = {1'b0, {(POS_W-1){1'b1}}};
            end

            // error to target and segment length, origin for the first waypoint
            prev[a]    = (idx_reg == '0) ? '0 : way[a];
            err[a]     = {tgt_reg[a][POS_W-1], tgt_reg[a]} - {pos_reg[a][POS_W-1], pos_reg[a]};
            seg[a]     = {tgt_reg[a][POS_W-1], tgt_reg[a]} - {prev[a][POS_W-1], prev[a]};
            err_abs[a] = err[a][POS_W] ? $unsigned(-err[a]) : $unsigned(err[a]);
            seg_abs[a] = seg[a][POS_W] ? $unsigned(-seg[a]) : $unsigned(seg[a]);

            // restoring division step
            div_sh[a]    = {rem_reg[a], quo_reg[a][NUM_W-1]};
            div_trial[a] = {1'b0, div_sh[a]} - {2'b00, len_reg[a]};

            // sign, saturation and floor for the command
            mag_lim[a] = neg_reg[a] ? NUM_W'(33'h0_8000_0000) : NUM_W'(33'h0_7FFF_FFFF);
            mag[a]     = (quo_reg[a] > mag_lim[a]) ? mag_lim[a][POS_W-1:0]
                                                   : quo_reg[a][POS_W-1:0];
            if (mag[a] != '0 && mag[a] <= {16'd0, regs.min_speed})
            begin
                mag[a] = {16'd0, regs.min_speed};
            end
            cmd_val[a] = neg_reg[a] ? $signed(-mag[a]) : $signed(mag[a]);
        end
    end

    // Course state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg[0] <= '0;
            pos_reg[1] <= '0;
            idx_reg    <= '0;
            fin_reg    <= 1'b0;
        end
        else if (cmd.restart)
        begin
            pos_reg[0] <= '0;
            pos_reg[1] <= '0;
            idx_reg    <= '0;
            fin_reg    <= 1'b0;
        end
        else if (cmd.pos_step)
        begin
            pos_reg[0] <= pos_sat[0];
            pos_reg[1] <= pos_sat[1];
            fin_reg    <= status.fin_now;
        end
        else if (cmd.fin_load && arr_reg[0] && arr_reg[1])
        begin
            idx_reg <= idx_inc;
            fin_reg <= (idx_inc >= count);
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 2; a++)
        begin
            if (cmd.capture)
            begin
                prod_reg[a] <= vel[a] * gain_s;
            end
            if (cmd.tgt_latch)
            begin
                tgt_reg[a] <= way[a];
            end
            if (cmd.err_calc)
            begin
                emag_reg[a] <= err_abs[a][POS_W-1:0];
                neg_reg[a]  <= err[a][POS_W];
                arr_reg[a]  <= (err_abs[a] <= {17'd0, regs.arrive_tol});
                len_reg[a]  <= (seg_abs[a] == '0) ? MIN_SEG_LEN : seg_abs[a][POS_W-1:0];
            end
            if (cmd.mul_start)
            begin
                quo_reg[a] <= NUM_W'(regs.max_speed * emag_reg[a]);
                rem_reg[a] <= '0;
            end
            else if (cmd.div_step)
            begin
                quo_reg[a] <= {quo_reg[a][NUM_W-2:0], !div_trial[a][POS_W+1]};
                rem_reg[a] <= div_trial[a][POS_W+1] ? div_sh[a][POS_W-1:0]
                                                    : div_trial[a][POS_W-1:0];
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.fin_load)
        begin
            out_cmd_reg[0] <= cmd_val[0];
            out_cmd_reg[1] <= cmd_val[1];
            out_pos_reg[0] <= pos_reg[0];
            out_pos_reg[1] <= pos_reg[1];
            out_idx_reg    <= (arr_reg[0] && arr_reg[1]) ? idx_inc : idx_reg;
            out_done_reg   <= 1'b0;
        end
        else if (cmd.done_load)
        begin
            out_cmd_reg[0] <= '0;
            out_cmd_reg[1] <= '0;
            out_pos_reg[0] <= pos_reg[0];
            out_pos_reg[1] <= pos_reg[1];
            out_idx_reg    <= idx_reg;
            out_done_reg   <= 1'b1;
        end
    end

    assign cmd_x        = out_cmd_reg[0];
    assign cmd_y        = out_cmd_reg[1];
    assign pos_x        = out_pos_reg[0];
    assign pos_y        = out_pos_reg[1];
    assign target_index = out_idx_reg;
    assign done_res     = out_done_reg;

endmodule

`default_nettype wire

/* rtl/core/waypoint_proportional_follower.sv */
// Waypoint proportional follower: dead reckoning plus per-axis proportional command.
//
// Channels: req carries items (tick, load waypoint, restart), rsp carries one
// result per tick, cfg writes the five registers (index 0..4, always ready).
// A transfer on req happens at a clock edge with valid and ready both high.
// Load and restart produce no result; the block is ready again in the next cycle.
// A tick runs from transfer to result valid through position update, two
// table reads (the second with the errors), gain multiply, the two bit-serial
// restoring dividers (one per axis, one quotient bit per cycle) and the result
// load; the block is ready for the next tick once the result is loaded.
// A tick on a finished course skips the table and divider: position update, then result load.
// req is ready only between items, so one tick is in flight at a time.
// The result sits in an output register; if the receiver stalls, a following
// load or restart is still taken, and a following tick holds in its last
// step until the result register is free.
// Reset clears position, waypoint index, finished flag, result valid and loads
// the register defaults; the waypoint table holds no reset value and each entry
// must be loaded before a tick reads it.
`default_nettype none

module waypoint_proportional_follower #(
    parameter int MAX_WAYPOINTS = 16
) (
    input wire logic  clk,
    input wire logic  rst_n,
    wpf_req_if.sink   req,
    wpf_rsp_if.source rsp,
    wpf_cfg_if.sink   cfg
);
    import wpf_pkg::*;

    logic [15:0]      max_speed_reg;
    logic [15:0]      min_speed_reg;
    logic [15:0]      arrive_tol_reg;
    logic [15:0]      step_gain_reg;
    logic [IDX_W-1:0] waypoint_count_reg;
    cfg_t             regs;
    dp_cmd_t          cmd;
    dp_status_t       status;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg      <= MAX_SPEED_RST;
            min_speed_reg      <= MIN_SPEED_RST;
            arrive_tol_reg     <= ARRIVE_TOL_RST;
            step_gain_reg      <= STEP_GAIN_RST;
            waypoint_count_reg <= WAYPOINT_COUNT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (reg_index_t'(cfg.index))
                REG_MAX_SPEED:      max_speed_reg      <= cfg.wdata;
                REG_MIN_SPEED:      min_speed_reg      <= cfg.wdata;
                REG_ARRIVE_TOL:     arrive_tol_reg     <= cfg.wdata;
                REG_STEP_GAIN:      step_gain_reg      <= cfg.wdata;
                REG_WAYPOINT_COUNT: waypoint_count_reg <= cfg.wdata[IDX_W-1:0];
                default:            ;
            endcase
        end
    end

    assign regs.max_speed      = max_speed_reg;
    assign regs.min_speed      = min_speed_reg;
    assign regs.arrive_tol     = arrive_tol_reg;
    assign regs.step_gain      = step_gain_reg;
    assign regs.waypoint_count = waypoint_count_reg;

    wpf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (req.action),
        .req_ready  (req.ready),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .status     (status),
        .cmd        (cmd)
    );

    wpf_datapath #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .regs         (regs),
        .vel_x        (req.vel_x),
        .vel_y        (req.vel_y),
        .slot         (req.slot),
        .way_x        (req.way_x),
        .way_y        (req.way_y),
        .cmd_x        (rsp.cmd_x),
        .cmd_y        (rsp.cmd_y),
        .pos_x        (rsp.pos_x),
        .pos_y        (rsp.pos_y),
        .target_index (rsp.target_index),
        .done_res     (rsp.done_res)
    );

endmodule

`default_nettype wire

/* rtl/core/wpf_checker.sv */
// Port-level checker for the waypoint proportional follower, bound to the top level.
`default_nettype none

module wpf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic [1:0]  req_action,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [31:0] cmd_x,
    input wire logic [31:0] cmd_y,
    input wire logic [31:0] pos_x,
    input wire logic [31:0] pos_y,
    input wire logic [4:0]  target_index,
    input wire logic        done_res
);
    import wpf_pkg::*;

    // A finished-course result always carries zero commands
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && done_res) |-> (cmd_x == '0 && cmd_y == '0))
        else $error("finished result with non-zero command");

    // A tick keeps the block busy in the following cycle
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_action == ACT_TICK) |=> !req_ready)
        else $error("request ready right after a tick transfer");

    // A new result only follows a cycle of work
    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result appeared without a tick in progress");

    // Stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(cmd_x) && $stable(cmd_y)
            && $stable(pos_x) && $stable(pos_y) && $stable(target_index)
            && $stable(done_res)))
        else $error("stalled result changed");

endmodule

bind waypoint_proportional_follower wpf_checker u_wpf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_action   (req.action),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .cmd_x        (rsp.cmd_x),
    .cmd_y        (rsp.cmd_y),
    .pos_x        (rsp.pos_x),
    .pos_y        (rsp.pos_y),
    .target_index (rsp.target_index),
    .done_res     (rsp.done_res)
);

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the waypoint proportional follower block.
module tb;
    import wpf_pkg::*;

    localparam int MAX_SLOTS      = 16;
    localparam int COORD_SPAN     = 262144;     // random near waypoints stay within +-2^18
    localparam int SETTLE_CYCLES  = 64;         // covers a full tick from transfer to result
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    typedef struct {
        logic signed [31:0] cmd_x;
        logic signed [31:0] cmd_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [4:0]         target_index;
        logic               done_res;
    } course_result_t;

    logic clk = 1'b0;
    logic rst_n;

    wpf_req_if req_ch ();
    wpf_rsp_if rsp_ch ();
    wpf_cfg_if cfg_ch ();

    waypoint_proportional_follower dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #4 clk = ~clk;

    // Predicted block state
    cfg_t               regs;
    logic signed [31:0] dr_pos_x, dr_pos_y;
    int unsigned        wp_index;
    bit                 course_finished;
    logic signed [31:0] wp_x_mem [MAX_SLOTS];
    logic signed [31:0] wp_y_mem [MAX_SLOTS];

    course_result_t pending_commands [$];

    // Run bookkeeping
    int  fail_count      = 0;
    int  results_checked = 0;
    int  items_sent      = 0;
    int  tick_count      = 0;
    int  load_count      = 0;
    int  restart_count   = 0;
    int  settings_used   = 0;
    int  arrival_count   = 0;
    int  finish_count    = 0;
    bit  idle_on         = 1'b1;
    int unsigned hold_cycles = 0;

    // ---------------------------------------------------------------- prediction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > longint'(S32_MAX))
            return S32_MAX;
        if (v < longint'(S32_MIN))
            return S32_MIN;
        return v[31:0];
    endfunction

    function automatic longint mag64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Effective course length: zero acts as one, capped at the table depth
    function automatic int unsigned course_length();
        int unsigned n;
        n = 32'(regs.waypoint_count);
        if (n == 0)
            n = 1;
        if (n > MAX_SLOTS)
            n = MAX_SLOTS;
        return n;
    endfunction

    // Proportional command for one axis, with zero-length segments as 1 cm
    function automatic logic signed [31:0] axis_command(longint err, longint seg);
        longint c;
        if (seg == 0)
            seg = 256;
        c = longint'(clamp32((longint'(regs.max_speed) * err) / seg));
        if (c != 0 && mag64(c) <= longint'(regs.min_speed))
            c = (c > 0) ? longint'(regs.min_speed) : -longint'(regs.min_speed);
        return c[31:0];
    endfunction

    // Dead-reckon one tick and form the commands toward the current waypoint
    function automatic course_result_t follow_tick(logic signed [31:0] vx,
                                                   logic signed [31:0] vy);
        course_result_t r;
        int unsigned    lim;
        longint         tx, ty, sx, sy, ex, ey;
        lim = course_length();
        dr_pos_x = clamp32(longint'(dr_pos_x) +
                           ((longint'(vx) * longint'(regs.step_gain)) >>> 16));
        dr_pos_y = clamp32(longint'(dr_pos_y) +
                           ((longint'(vy) * longint'(regs.step_gain)) >>> 16));
        if (wp_index >= lim)
            course_finished = 1'b1;
        r.done_res = course_finished;
        r.cmd_x    = '0;
        r.cmd_y    = '0;
        if (!r.done_res)
        begin
            tx = longint'(wp_x_mem[wp_index]);
            ty = longint'(wp_y_mem[wp_index]);
            sx = 0;
            sy = 0;
            if (wp_index > 0)
            begin
                sx = longint'(wp_x_mem[wp_index - 1]);
                sy = longint'(wp_y_mem[wp_index - 1]);
            end
            ex = tx - longint'(dr_pos_x);
            ey = ty - longint'(dr_pos_y);
            r.cmd_x = axis_command(ex, mag64(tx - sx));
            r.cmd_y = axis_command(ey, mag64(ty - sy));
            if (mag64(ex) <= longint'(regs.arrive_tol) &&
                mag64(ey) <= longint'(regs.arrive_tol))
            begin
                wp_index++;
                arrival_count++;
                if (wp_index >= lim)
                begin
                    course_finished = 1'b1;
                    finish_count++;
                end
            end
        end
        r.pos_x        = dr_pos_x;
        r.pos_y        = dr_pos_y;
        r.target_index = wp_index[4:0];
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic int near_coord();
        return int'($urandom_range(0, 2 * COORD_SPAN)) - COORD_SPAN;
    endfunction

    // Smallest velocity whose increment is exactly delta at the current gain
    function automatic logic signed [31:0] velocity_for(longint delta);
        longint g, num, v;
        g = longint'(regs.step_gain);
        if (g == 0)
            return $urandom;
        num = delta * 65536;
        v = (num >= 0) ? (num + g - 1) / g : -((-num) / g);
        return clamp32(v);
    endfunction

    function automatic cfg_t make_settings(logic [15:0] ms, logic [15:0] mn,
                                           logic [15:0] tol, logic [15:0] gain,
                                           logic [IDX_W-1:0] cnt);
        cfg_t s;
        s.max_speed      = ms;
        s.min_speed      = mn;
        s.arrive_tol     = tol;
        s.step_gain      = gain;
        s.waypoint_count = cnt;
        return s;
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        s.max_speed      = 16'($urandom);
        s.min_speed      = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 2000));
        s.arrive_tol     = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 400));
        s.step_gain      = 16'($urandom_range(32, 65535));
        s.waypoint_count = ($urandom_range(0, 5) == 0) ? IDX_W'($urandom)
                                                       : IDX_W'($urandom_range(1, 16));
        return s;
    endfunction

    // One item transfer on the request channel; prediction at acceptance
    task automatic send_item(action_t act, logic signed [31:0] a, logic signed [31:0] b,
                             int unsigned slot_no);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.slot   <= 4'(slot_no);
        req_ch.vel_x  <= (act == ACT_TICK) ? a : $urandom;
        req_ch.vel_y  <= (act == ACT_TICK) ? b : $urandom;
        req_ch.way_x  <= (act == ACT_LOAD) ? a : $urandom;
        req_ch.way_y  <= (act == ACT_LOAD) ? b : $urandom;
        do @(posedge clk); while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
        case (act)
            ACT_TICK:
            begin
                pending_commands.push_back(follow_tick(a, b));
                tick_count++;
            end
            ACT_LOAD:
            begin
                wp_x_mem[4'(slot_no)] = a;
                wp_y_mem[4'(slot_no)] = b;
                load_count++;
            end
            ACT_RESTART:
            begin
                dr_pos_x        = '0;
                dr_pos_y        = '0;
                wp_index        = 0;
                course_finished = 1'b0;
                restart_count++;
            end
            default: ;
        endcase
        if (act != ACT_NONE)
            items_sent++;
    endtask

    // Tick that moves part of the way to the waypoint, or lands within tolerance
    task automatic steer_tick(bit land);
        longint      dx, dy;
        int unsigned t;
        if (course_finished || wp_index >= MAX_SLOTS)
        begin
            send_item(ACT_TICK, velocity_for(near_coord()), velocity_for(near_coord()),
                      $urandom);
            return;
        end
        dx = longint'(wp_x_mem[wp_index]) - longint'(dr_pos_x);
        dy = longint'(wp_y_mem[wp_index]) - longint'(dr_pos_y);
        if (land)
        begin
            t  = (regs.arrive_tol > 16'd1000) ? 1000 : 32'(regs.arrive_tol);
            dx = dx + (int'($urandom_range(0, 2 * t)) - int'(t));
            dy = dy + (int'($urandom_range(0, 2 * t)) - int'(t));
        end
        else
        begin
            t  = $urandom_range(1, 3);
            dx = dx * longint'(t) / 4;
            dy = dy * longint'(t) / 4;
        end
        send_item(ACT_TICK, velocity_for(dx), velocity_for(dy), $urandom);
    endtask

    // Drop valid, let every pending result drain, then let the block settle
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_commands.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= val;
        do @(posedge clk); while (!(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1));
        case (idx)
            REG_MAX_SPEED:      regs.max_speed      = val;
            REG_MIN_SPEED:      regs.min_speed      = val;
            REG_ARRIVE_TOL:     regs.arrive_tol     = val;
            REG_STEP_GAIN:      regs.step_gain      = val;
            REG_WAYPOINT_COUNT: regs.waypoint_count = val[IDX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(cfg_t s);
        wait_idle();
        write_reg(REG_MAX_SPEED, s.max_speed);
        write_reg(REG_MIN_SPEED, s.min_speed);
        write_reg(REG_ARRIVE_TOL, s.arrive_tol);
        write_reg(REG_STEP_GAIN, s.step_gain);
        write_reg(REG_WAYPOINT_COUNT, 16'(s.waypoint_count));
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // Fresh course: optional reload, restart, then mostly steering ticks with noise
    task automatic run_course();
        int unsigned lim, k, budget, tail, pick;
        lim = course_length();
        if ($urandom_range(0, 3) != 0)
        begin
            for (k = 0; k < lim; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    // zero-length segment: repeat previous point, or the origin first
                    if (k > 0)
                        send_item(ACT_LOAD, wp_x_mem[k-1], wp_y_mem[k-1], k);
                    else
                        send_item(ACT_LOAD, 0, 0, k);
                end
                else
                    send_item(ACT_LOAD, near_coord(), near_coord(), k);
            end
        end
        send_item(ACT_RESTART, $urandom, $urandom, $urandom);
        tail   = $urandom_range(0, 2);
        budget = 4 * lim + 8;
        while (budget != 0)
        begin
            budget--;
            if (course_finished)
            begin
                if (tail == 0)
                    break;
                tail--;
            end
            pick = $urandom_range(0, 39);
            if (pick == 0)
                send_item(ACT_NONE, $urandom, $urandom, $urandom);
            else if (pick == 1)
                send_item(ACT_RESTART, $urandom, $urandom, $urandom);
            else if (pick == 2)
                send_item(ACT_LOAD, $urandom, $urandom, $urandom);
            else if (pick < 5)
                send_item(ACT_TICK, $urandom, $urandom, $urandom);
            else
                steer_tick(pick < 18);
        end
    endtask

    // ---------------------------------------------------------------- tests

    // Reset register values, table fill with extreme entries, extreme velocities
    task automatic test_defaults();
        int s;
        for (s = 0; s < MAX_SLOTS; s++)
        begin
            if (s == 0)
                send_item(ACT_LOAD, 0, 5000, s);
            else if (s == 14)
                send_item(ACT_LOAD, S32_MAX, S32_MIN, s);
            else if (s == 15)
                send_item(ACT_LOAD, S32_MIN, S32_MAX, s);
            else
                send_item(ACT_LOAD, near_coord(), near_coord(), s);
        end
        send_item(ACT_TICK, 0, 0, 0);
        send_item(ACT_TICK, 0, 5000 * 256, 0);
        send_item(ACT_TICK, S32_MIN, S32_MAX, 0);
        send_item(ACT_TICK, S32_MAX, S32_MIN, 0);
        send_item(ACT_TICK, -1, 1, 0);
        send_item(ACT_NONE, $urandom, $urandom, $urandom);
        send_item(ACT_RESTART, $urandom, $urandom, $urandom);
        send_item(ACT_TICK, 0, 0, 0);
    endtask

    // All-ones and all-zero registers, count out of range, count dropped
    // below the index, and the minimum-speed floor
    task automatic test_register_extremes();
        apply_settings(make_settings(16'hffff, 16'hffff, 16'hffff, 16'hffff, 5'd0));
        send_item(ACT_LOAD, 256, -256, 0);
        send_item(ACT_RESTART, 0, 0, 0);
        send_item(ACT_TICK, S32_MIN, S32_MAX, 0);     // position and commands saturate
        send_item(ACT_TICK, S32_MIN, S32_MAX, 0);
        send_item(ACT_RESTART, 0, 0, 0);
        steer_tick(1'b1);                             // arrival finishes a one-point course
        send_item(ACT_TICK, $urandom, $urandom, 0);

        apply_settings(make_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'd31));
        send_item(ACT_RESTART, 0, 0, 0);
        send_item(ACT_TICK, $urandom, $urandom, 0);
        send_item(ACT_LOAD, 0, 0, 0);
        send_item(ACT_TICK, $urandom, $urandom, 0);
        send_item(ACT_TICK, $urandom, $urandom, 0);

        apply_settings(make_settings(16'd1, 16'd10, 16'd0, 16'd256, 5'd1));
        send_item(ACT_TICK, 0, 0, 0);
        send_item(ACT_RESTART, 0, 0, 0);
        send_item(ACT_LOAD, 256, -256, 0);
        send_item(ACT_TICK, 0, 0, 0);
    endtask

    task automatic test_random_courses();
        int goal;
        repeat (7)
        begin
            apply_settings(random_settings());
            goal = items_sent + 180;
            while (items_sent < goal)
                run_course();
        end
    endtask

    // Receiver holds off long enough for the block to back up its input
    task automatic test_backpressure();
        apply_settings(make_settings(16'd19661, 16'd655, 16'd20, 16'd256, 5'd8));
        send_item(ACT_RESTART, 0, 0, 0);
        hold_cycles = 600;
        repeat (14) steer_tick($urandom_range(0, 1));
    endtask

    task automatic test_steady_stream();
        int goal;
        apply_settings(random_settings());
        idle_on = 1'b0;
        goal = items_sent + 150;
        while (items_sent < goal)
            run_course();
    endtask

    // ---------------------------------------------------------------- checking

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= 40)
                $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
        end
    endfunction

    initial
    begin
        course_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (pending_commands.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 40)
                        $error("result transfer with no tick pending");
                end
                else
                begin
                    want = pending_commands.pop_front();
                    compare_field("cmd_x", want.cmd_x, rsp_ch.cmd_x);
                    compare_field("cmd_y", want.cmd_y, rsp_ch.cmd_y);
                    compare_field("pos_x", want.pos_x, rsp_ch.pos_x);
                    compare_field("pos_y", want.pos_y, rsp_ch.pos_y);
                    compare_field("target_index", 32'(want.target_index),
                                  32'(rsp_ch.target_index));
                    compare_field("done_res", 32'(want.done_res), 32'(rsp_ch.done_res));
                    results_checked++;
                end
            end
        end
    end

    // Result receiver: random stall bursts, plus a long hold-off on request
    initial
    begin
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Run watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * 8);
        $display("waypoint_proportional_follower verification failed");
        $finish;
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        rst_n         <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.action <= ACT_NONE;
        req_ch.vel_x  <= '0;
        req_ch.vel_y  <= '0;
        req_ch.slot   <= '0;
        req_ch.way_x  <= '0;
        req_ch.way_y  <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= REG_MAX_SPEED;
        cfg_ch.wdata  <= '0;

        regs            = make_settings(MAX_SPEED_RST, MIN_SPEED_RST, ARRIVE_TOL_RST,
                                        STEP_GAIN_RST, WAYPOINT_COUNT_RST);
        dr_pos_x        = '0;
        dr_pos_y        = '0;
        wp_index        = 0;
        course_finished = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_register_extremes();
        test_random_courses();
        test_backpressure();
        test_steady_stream();
        wait_idle();

        $display("Run covered %0d ticks, %0d table loads and %0d restarts over %0d settings.",
                 tick_count, load_count, restart_count, settings_used);
        $display("Checked %0d results: %0d waypoint arrivals, %0d courses finished.",
                 results_checked, arrival_count, finish_count);
        if (fail_count == 0)
            $display("waypoint_proportional_follower verification clean");
        else
            $display("waypoint_proportional_follower verification failed");
        $finish;
    end

endmodule

/* files.f */
rtl/core/wpf_pkg.sv
rtl/core/wpf_ifs.sv
rtl/core/wpf_ram.sv
rtl/core/wpf_ctrl.sv
rtl/core/wpf_datapath.sv
rtl/core/waypoint_proportional_follower.sv
rtl/core/wpf_checker.sv
tb/tb.sv
